### rtl/srde_pkg.sv
// ----------------------------------------------------------------------------
// srde_pkg
// Shared constants and helpers for the signed radix digit emitter.
// ----------------------------------------------------------------------------
package srde_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_RADIX   = 16;
  localparam int RADIX_W     = 5;
  localparam int SYMBOLS_W   = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int DIGIT_W     = $clog2(MAX_RADIX);
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
  localparam int DIG_CNT_W   = $clog2(VALUE_WIDTH + 1);

  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_ZERO  = 8'h30;

  localparam logic [RADIX_W-1:0]   RADIX_RST    = RADIX_W'(10);
  localparam logic [SYMBOLS_W-1:0] SYM_LOW_RST  = 64'h3736353433323130;
  localparam logic [SYMBOLS_W-1:0] SYM_HIGH_RST = 64'h0000000000003938;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX    = 2'd0,
    REG_SYM_LOW  = 2'd1,
    REG_SYM_HIGH = 2'd2,
    REG_UNUSED   = 2'd3
  } cfg_reg_e;

  // Symbol byte for digit d; digits 0..7 in the low word, 8..15 in the high word.
  function automatic logic [7:0] symbol_of(logic [DIGIT_W-1:0] d,
                                           logic [SYMBOLS_W-1:0] lo,
                                           logic [SYMBOLS_W-1:0] hi);
    logic [2*SYMBOLS_W-1:0] tbl;
    tbl = {hi, lo};
    return tbl[{d, 3'b000} +: 8];
  endfunction

  // Base is usable when radix is in range and the used symbols are legal and distinct.
  function automatic logic base_ok(logic [RADIX_W-1:0] n,
                                   logic [SYMBOLS_W-1:0] lo,
                                   logic [SYMBOLS_W-1:0] hi);
    logic ok;
    logic [7:0] si;
    ok = (n >= RADIX_W'(2)) && (n <= RADIX_W'(MAX_RADIX));
    for (int i = 0; i < MAX_RADIX; i++) begin
      si = symbol_of(DIGIT_W'(i), lo, hi);
      if (RADIX_W'(i) < n) begin
        if (si == SYM_MINUS || si == SYM_PLUS || si == 8'h00) ok = 1'b0;
        for (int j = i + 1; j < MAX_RADIX; j++) begin
          if (RADIX_W'(j) < n && symbol_of(DIGIT_W'(j), lo, hi) == si) ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

endpackage

### rtl/signed_radix_digit_emitter.sv
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter
// Converts a signed integer to text in a configurable radix, one symbol per
// strobe, most significant first, with a leading '-' for negative values.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------
//  request  | start_i, busy_o          | value_i
//  result   | valid_o (1-cycle strobe) | symbol_o, last_o
//  config   | cfg_valid_i, cfg_ready_o | cfg_index_i, cfg_data_i
//
//  Each digit comes from a bit-serial long division of the magnitude by the
//  radix, one dividend bit per cycle over all VALUE_WIDTH bits for each digit.
//  A nonzero request keeps busy_o high through division, the sign and the
//  digits; zero and an invalid base never raise busy_o.
//  Reset restores radix 10 and the table "0123456789". The receiver cannot
//  stall; results leave at one per cycle once the digits are ready.
//
module signed_radix_digit_emitter (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic signed [srde_pkg::VALUE_WIDTH-1:0] value_i,
  output logic                                  valid_o,
  output logic [7:0]                            symbol_o,
  output logic                                  last_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [srde_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [srde_pkg::SYMBOLS_W-1:0]        cfg_data_i
);

  import srde_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } state_e;

  state_e                   state_q;
  logic [RADIX_W-1:0]       radix_q;
  logic [SYMBOLS_W-1:0]     sym_low_q, sym_high_q;
  logic [VALUE_WIDTH-1:0]   mag_q, mag_d;
  logic [DIGIT_W-1:0]       rem_q, rem_d;
  logic [BIT_CNT_W-1:0]     bit_cnt_q;
  logic [DIG_CNT_W-1:0]     dig_cnt_q;
  logic                     neg_q;
  logic [DIGIT_W-1:0]       stack_q [VALUE_WIDTH];

  logic                     accept;
  logic                     base_valid;
  logic [DIGIT_W:0]         trial;
  logic                     q_bit;
  logic                     last_bit;
  logic [VALUE_WIDTH-1:0]   mag_abs;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign base_valid  = base_ok(radix_q, sym_low_q, sym_high_q);
  assign mag_abs     = value_i[VALUE_WIDTH-1] ? VALUE_WIDTH'(-value_i) : VALUE_WIDTH'(value_i);

  // restoring division step
  assign trial    = {rem_q, mag_q[VALUE_WIDTH-1]};
  assign q_bit    = (RADIX_W'(trial) >= radix_q);
  assign rem_d    = q_bit ? DIGIT_W'(RADIX_W'(trial) - radix_q) : DIGIT_W'(trial);
  assign mag_d    = {mag_q[VALUE_WIDTH-2:0], q_bit};
  assign last_bit = (bit_cnt_q == BIT_CNT_W'(VALUE_WIDTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q    <= RADIX_RST;
      sym_low_q  <= SYM_LOW_RST;
      sym_high_q <= SYM_HIGH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_RADIX:    radix_q    <= cfg_data_i[RADIX_W-1:0];
        REG_SYM_LOW:  sym_low_q  <= cfg_data_i;
        REG_SYM_HIGH: sym_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // digit stack: push at the bottom during division, pop from the bottom on emit
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV && last_bit) begin
      stack_q[0] <= rem_d;
      for (int i = 1; i < VALUE_WIDTH; i++) stack_q[i] <= stack_q[i-1];
    end else if (state_q == ST_EMIT) begin
      for (int i = 0; i < VALUE_WIDTH - 1; i++) stack_q[i] <= stack_q[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mag_q     <= '0;
      rem_q     <= '0;
      bit_cnt_q <= '0;
      dig_cnt_q <= '0;
      neg_q     <= 1'b0;
      valid_o   <= 1'b0;
      symbol_o  <= '0;
      last_o    <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept && base_valid) begin
            if (value_i == '0) begin
              mag_q     <= '0;
              dig_cnt_q <= '0;
              valid_o   <= 1'b1;
              symbol_o  <= SYM_ZERO;
              last_o    <= 1'b1;
            end else begin
              mag_q     <= mag_abs;
              neg_q     <= value_i[VALUE_WIDTH-1];
              rem_q     <= '0;
              bit_cnt_q <= '0;
              dig_cnt_q <= '0;
              state_q   <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          mag_q <= mag_d;
          if (last_bit) begin
            dig_cnt_q <= dig_cnt_q + DIG_CNT_W'(1);
            rem_q     <= '0;
            bit_cnt_q <= '0;
            if (mag_d == '0) begin
              state_q <= neg_q ? ST_SIGN : ST_EMIT;
            end
          end else begin
            rem_q     <= rem_d;
            bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
          end
        end
        ST_SIGN: begin
          valid_o  <= 1'b1;
          symbol_o <= SYM_MINUS;
          last_o   <= 1'b0;
          state_q  <= ST_EMIT;
        end
        ST_EMIT: begin
          valid_o   <= 1'b1;
          symbol_o  <= symbol_of(stack_q[0], sym_low_q, sym_high_q);
          last_o    <= (dig_cnt_q == DIG_CNT_W'(1));
          dig_cnt_q <= dig_cnt_q - DIG_CNT_W'(1);
          if (dig_cnt_q == DIG_CNT_W'(1)) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // the partial remainder always stays below the radix
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> RADIX_W'(rem_q) < radix_q)
    else $error("remainder out of range");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> dig_cnt_q != '0)
    else $error("emitting with empty digit stack");

  a_digit_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_cnt_q <= DIG_CNT_W'(VALUE_WIDTH))
    else $error("digit count overflow");

  a_no_strobe_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> !valid_o)
    else $error("result strobe during division");

  a_sign_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SIGN |=> valid_o && symbol_o == SYM_MINUS && !last_o)
    else $error("sign not emitted ahead of digits");

endmodule

### tb/signed_radix_digit_emitter_tb.sv
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter_tb
// Drives signed values through the radix emitter under a series of radix and
// symbol table settings. Every emitted character is checked against typed-in
// text or a behavioral renderer that keeps its own copy of the configuration.
// ----------------------------------------------------------------------------
module signed_radix_digit_emitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srde_pkg::*;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
  } out_char_t;

  typedef enum bit {ROW_CFG, ROW_VALUE} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    cfg_reg_e               reg_idx;
    logic [SYMBOLS_W-1:0]   data;
    logic signed [31:0]     value;
    bit                     typed;
    logic [95:0]            text;
  } stim_row_t;

  localparam int ITEM_TARGET  = 380;
  localparam int DRAIN_CYCLES = 1100;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start_i = 1'b0;
  logic                          busy_o;
  logic signed [VALUE_WIDTH-1:0] value_i = '0;
  logic                          valid_o;
  logic [7:0]                    symbol_o;
  logic                          last_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [CFG_IDX_W-1:0]          cfg_index_i = '0;
  logic [SYMBOLS_W-1:0]          cfg_data_i = '0;

  // Local copy of the configuration registers.
  logic [RADIX_W-1:0]   cur_radix  = RADIX_RST;
  logic [SYMBOLS_W-1:0] cur_sym_lo = SYM_LOW_RST;
  logic [SYMBOLS_W-1:0] cur_sym_hi = SYM_HIGH_RST;

  out_char_t pending_chars[$];
  out_char_t got_want;
  int        fail_count = 0;
  bit        quiet = 1'b0;

  stim_row_t directed_rows[$];

  always #10 clk_i = ~clk_i;

  signed_radix_digit_emitter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .value_i     (value_i),
    .valid_o     (valid_o),
    .symbol_o    (symbol_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  function automatic void flag_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  function automatic bit base_usable();
    logic [2*SYMBOLS_W-1:0] tbl;
    logic [7:0]             s;
    tbl = {cur_sym_hi, cur_sym_lo};
    if (cur_radix < 2 || cur_radix > MAX_RADIX) return 1'b0;
    for (int i = 0; i < int'(cur_radix); i++) begin
      s = tbl[8*i +: 8];
      if (s == SYM_MINUS || s == SYM_PLUS || s == 8'h00) return 1'b0;
      for (int j = 0; j < i; j++) begin
        if (tbl[8*j +: 8] == s) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Expected characters of one value under the current base.
  function automatic void render_value(input logic signed [31:0] v);
    logic [2*SYMBOLS_W-1:0] tbl;
    logic [31:0]            mag;
    logic [3:0]             digs [32];
    int                     n;
    tbl = {cur_sym_hi, cur_sym_lo};
    n = 0;
    if (!base_usable()) return;
    if (v == 0) begin
      pending_chars.push_back('{SYM_ZERO, 1'b1});
      return;
    end
    mag = v[31] ? (~v + 32'd1) : v;
    while (mag != 0) begin
      digs[n] = 4'(mag % cur_radix);
      mag = mag / cur_radix;
      n++;
    end
    if (v[31]) pending_chars.push_back('{SYM_MINUS, 1'b0});
    for (int k = n - 1; k >= 0; k--) begin
      pending_chars.push_back('{tbl[8*digs[k] +: 8], k == 0});
    end
  endfunction

  // Typed-in expectation: nonzero bytes of the packed text, left to right.
  function automatic void push_typed(input logic [95:0] text);
    logic [7:0] chars[$];
    for (int b = 11; b >= 0; b--) begin
      if (text[8*b +: 8] != 8'h00) chars.push_back(text[8*b +: 8]);
    end
    foreach (chars[i]) pending_chars.push_back('{chars[i], i == chars.size() - 1});
  endfunction

  function automatic stim_row_t cfg_row(input cfg_reg_e idx, input logic [63:0] data);
    return '{ROW_CFG, idx, data, 32'sd0, 1'b0, 96'd0};
  endfunction

  function automatic stim_row_t val_row(input logic signed [31:0] v);
    return '{ROW_VALUE, REG_RADIX, 64'd0, v, 1'b0, 96'd0};
  endfunction

  function automatic stim_row_t val_typed(input logic signed [31:0] v,
                                          input logic [95:0] text);
    return '{ROW_VALUE, REG_RADIX, 64'd0, v, 1'b1, text};
  endfunction

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    longint             p;
    int                 r;
    r = (cur_radix >= 2) ? int'(cur_radix) : 2;
    p = 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4: v = $urandom_range(0, 40);
      5: begin
        v = $urandom_range(1, 40);
        v = -v;
      end
      6: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh80000000;
          1: v = 32'sh7FFFFFFF;
          2: v = 32'sd0;
          default: v = -32'sd1;
        endcase
      end
      7: begin
        // powers of the radix and their neighbors: digit count boundaries
        repeat ($urandom_range(1, 31)) begin
          if (p * r <= 64'sd2147483648) p = p * r;
        end
        v = 32'(p - longint'($urandom_range(0, 1)));
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] data);
    start_i <= 1'b0;
    while (pending_chars.size() != 0 || busy_o) @(posedge clk_i);
    // an item with an invalid base may still be finishing
    repeat (4 + $urandom_range(0, 3)) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_RADIX:    cur_radix  = data[RADIX_W-1:0];
      REG_SYM_LOW:  cur_sym_lo = data;
      REG_SYM_HIGH: cur_sym_hi = data;
      default: ;
    endcase
  endtask

  task automatic issue_value(input logic signed [31:0] v, input bit typed,
                             input logic [95:0] text);
    if (!quiet && $urandom_range(0, 99) < 28) begin
      start_i <= 1'b0;
      if ($urandom_range(0, 1)) begin
        @(posedge clk_i);
        while (busy_o) @(posedge clk_i);
      end
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy_o);
    if (typed) push_typed(text);
    else render_value(v);
  endtask

  // Build a symbol table whose used bytes are legal and distinct; unused
  // bytes are left random.
  task automatic random_table(input int n, output logic [127:0] tbl);
    bit         used [256];
    logic [7:0] s;
    tbl = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < n; i++) begin
      do s = 8'($urandom_range(1, 255));
      while (s == SYM_MINUS || s == SYM_PLUS || used[s]);
      used[s] = 1'b1;
      tbl[8*i +: 8] = s;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (pending_chars.size() == 0) begin
        flag_failure($sformatf("unexpected symbol %02h last %0b", symbol_o, last_o));
      end else begin
        got_want = pending_chars.pop_front();
        if (symbol_o !== got_want.sym || last_o !== got_want.last) begin
          flag_failure($sformatf("mismatch: expected symbol %02h last %0b, got %02h last %0b",
                                 got_want.sym, got_want.last, symbol_o, last_o));
        end
      end
    end
  end

  initial begin
    logic [127:0]       tbl;
    logic [63:0]        radix_word;
    int                 radix_n;
    int                 n_items;
    int                 valid_items;
    int                 phase;
    int                 a;
    int                 b;
    bit                 broken;
    valid_items = 0;
    phase = 0;

    directed_rows = '{
      val_typed(32'sd0, "0"),
      val_typed(32'sd7, "7"),
      val_typed(-32'sd1, "-1"),
      val_typed(32'sh7FFFFFFF, "2147483647"),
      val_typed(32'sh80000000, "-2147483648"),
      cfg_row(REG_RADIX, 64'd16),
      cfg_row(REG_SYM_HIGH, "FEDCBA98"),
      val_typed(32'sh80000000, "-80000000"),
      val_typed(32'sh7FFFFFFF, "7FFFFFFF"),
      val_typed(32'sh01234567, "1234567"),
      val_row(32'shFEDCBA98),
      // high-bit symbols
      cfg_row(REG_SYM_LOW, 64'hF7F6F5F4F3F2F1F0),
      cfg_row(REG_SYM_HIGH, 64'hFFFEFDFCFBFAF9F8),
      val_row(-32'sd2),
      // radix 2 on 'a'/'b'; bytes above the radix are illegal and ignored
      cfg_row(REG_RADIX, 64'd2),
      cfg_row(REG_SYM_LOW, 64'h00002B2D2D2B6261),
      val_typed(32'sd0, "0"),
      val_typed(-32'sd3, "-bb"),
      val_typed(32'sd6, "bba"),
      val_row(32'sh80000000),
      val_row(32'sh7FFFFFFF),
      // radix out of range: no output
      cfg_row(REG_RADIX, 64'd0),
      val_typed(32'sd5, 96'd0),
      cfg_row(REG_RADIX, 64'd1),
      val_typed(32'sd0, 96'd0),
      cfg_row(REG_RADIX, 64'd17),
      val_typed(-32'sd1, 96'd0),
      cfg_row(REG_RADIX, 64'd31),
      val_typed(32'sd100, 96'd0),
      // forbidden symbols now in use
      cfg_row(REG_RADIX, 64'd16),
      val_typed(32'sd1, 96'd0),
      cfg_row(REG_SYM_LOW, SYM_LOW_RST),
      cfg_row(REG_SYM_HIGH, "FEDCBA98"),
      val_typed(32'sd255, "FF"),
      cfg_row(REG_SYM_HIGH, 64'h2B45444342413938),
      val_typed(-32'sd5, 96'd0),
      // digit 9 repeats digit 0
      cfg_row(REG_RADIX, 64'd10),
      cfg_row(REG_SYM_HIGH, 64'h4645444342413038),
      val_typed(32'sd42, 96'd0),
      cfg_row(REG_RADIX, 64'd9),
      val_typed(32'sd80, "88"),
      // nonexistent register: write has no effect
      cfg_row(REG_UNUSED, 64'hFFFFFFFFFFFFFFFF),
      val_typed(32'sd8, "8")
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        write_reg(directed_rows[r].reg_idx, directed_rows[r].data);
      end else begin
        issue_value(directed_rows[r].value, directed_rows[r].typed, directed_rows[r].text);
      end
    end

    while (valid_items < ITEM_TARGET) begin
      phase++;
      quiet = (phase >= 4 && phase <= 6);
      case ($urandom_range(0, 3))
        0: radix_n = $urandom_range(0, 1) ? 2 : MAX_RADIX;
        default: radix_n = $urandom_range(2, MAX_RADIX);
      endcase
      random_table(radix_n, tbl);
      broken = ($urandom_range(0, 7) == 0);
      if (broken) begin
        case ($urandom_range(0, 2))
          0: radix_n = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
          1: begin
            a = $urandom_range(0, radix_n - 1);
            case ($urandom_range(0, 2))
              0: tbl[8*a +: 8] = SYM_MINUS;
              1: tbl[8*a +: 8] = SYM_PLUS;
              default: tbl[8*a +: 8] = 8'h00;
            endcase
          end
          default: begin
            a = $urandom_range(0, radix_n - 1);
            do b = $urandom_range(0, radix_n - 1); while (b == a);
            tbl[8*b +: 8] = tbl[8*a +: 8];
          end
        endcase
      end
      radix_word = {$urandom, $urandom};
      radix_word[RADIX_W-1:0] = RADIX_W'(radix_n);
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
      write_reg(REG_SYM_HIGH, tbl[127:64]);
      write_reg(REG_RADIX, radix_word);
      write_reg(REG_SYM_LOW, tbl[63:0]);
      n_items = base_usable() ? $urandom_range(15, 35) : 4;
      repeat (n_items) begin
        issue_value(pick_value(), 1'b0, 96'd0);
        if (base_usable()) valid_items++;
      end
    end
    start_i <= 1'b0;

    while (pending_chars.size() != 0 || busy_o) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_chars.size() != 0) begin
      flag_failure($sformatf("%0d expected symbols never arrived", pending_chars.size()));
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
